// ----- design/buddy_block_allocator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Buddy allocator assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`endif

// ----- design/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_ORDER_DEF    = 9;
  localparam int MIN_ORDER_DEF    = 1;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int REQ_W   = 16;
  localparam int OFFIN_W = 9;
  localparam int ORDOUT_W = 4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    lvl_up;
    logic    scan_take;
    logic    split_step;
    logic    split_wr;
    logic    alloc_commit;
    logic    free_release;
    logic    merge_step;
    logic    set_commit;
    logic    err;
    status_t err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic row_any;
    logic lvl_top;
    logic lvl_at_tgt;
    logic free_bad;
    logic mate_free;
  } dp_sts_t;

endpackage

// ----- design/bba_ram.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bba_dp.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Per-level free bitmaps, block order store, in-use bits and work registers.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
  parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
  parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd,
  input  logic [bba_pkg::REQ_W-1:0]     req_bytes,
  input  logic [bba_pkg::OFFIN_W-1:0]   free_offset,
  input  bba_pkg::dp_cmd_t              ctl,
  output bba_pkg::dp_sts_t              sts,
  output logic [1:0]                    status,
  output logic [bba_pkg::OFFIN_W-1:0]   block_offset,
  output logic [bba_pkg::ORDOUT_W-1:0]  block_order
);

  localparam int DEPTH_LV = MAX_ORDER - MIN_ORDER;
  localparam int ROWS     = DEPTH_LV + 1;
  localparam int LEAF     = 1 << DEPTH_LV;
  localparam int LVL_W    = $clog2(ROWS);
  localparam int IDX_W    = DEPTH_LV;
  localparam int OFF_W    = MAX_ORDER;
  localparam int ORD_W    = $clog2(MAX_ORDER + 1);
  localparam int TOT_W    = bba_pkg::REQ_W + 1;

  logic [OFF_W-1:0] cur_off;
  logic [LVL_W-1:0] cur_lvl;
  logic [LVL_W-1:0] tgt_lvl;
  logic             is_free;
  logic             too_large;
  logic             oob;
  logic [ROWS-1:0]  row_valid;
  logic [LEAF-1:0]  in_use;
  logic             in_use_rd;
  logic [1:0]       res_status;
  logic [OFF_W-1:0] res_off;
  logic [ORD_W-1:0] res_ord;

  logic [LEAF-1:0]  row_rd;
  logic [LEAF-1:0]  row_eff;
  logic [LEAF-1:0]  row_wdata;
  logic             row_we;
  logic [ORD_W-1:0] ord_rd;
  logic [ORD_W-1:0] ord_cur;
  logic [IDX_W-1:0] idx_cur;
  logic [IDX_W-1:0] leaf;
  logic [IDX_W-1:0] first_j;
  logic [TOT_W-1:0] total;
  int               k_calc;
  logic             mis;

  assign ord_cur = ORD_W'(cur_lvl) + ORD_W'(MIN_ORDER);
  assign idx_cur = IDX_W'(cur_off >> ord_cur);
  assign leaf    = cur_off[OFF_W-1:MIN_ORDER];
  assign total   = TOT_W'(req_bytes) + TOT_W'(HEADER_BYTES);

  assign row_eff = row_valid[cur_lvl] ? row_rd :
                   ((cur_lvl == LVL_W'(DEPTH_LV)) ? LEAF'(1) : '0);

  always_comb begin
    k_calc = MAX_ORDER;
    for (int o = MAX_ORDER; o >= MIN_ORDER; o--) begin
      if (32'(total) <= (32'd1 << o)) begin
        k_calc = o;
      end
    end
  end

  always_comb begin
    first_j = '0;
    for (int i = LEAF - 1; i >= 0; i--) begin
      if (row_eff[i]) begin
        first_j = IDX_W'(i);
      end
    end
  end

  always_comb begin
    mis = 1'b0;
    for (int b = 0; b < OFF_W; b++) begin
      if ((b < int'(ord_rd)) && cur_off[b]) begin
        mis = 1'b1;
      end
    end
  end

  always_comb begin
    row_we    = 1'b0;
    row_wdata = row_eff;
    priority if (ctl.scan_take) begin
      row_we    = 1'b1;
      row_wdata = row_eff & ~(LEAF'(1) << first_j);
    end else if (ctl.split_wr) begin
      row_we    = 1'b1;
      row_wdata = row_eff | (LEAF'(1) << (idx_cur | IDX_W'(1)));
    end else if (ctl.merge_step) begin
      row_we    = 1'b1;
      row_wdata = row_eff & ~(LEAF'(1) << (idx_cur ^ IDX_W'(1)));
    end else if (ctl.set_commit) begin
      row_we    = 1'b1;
      row_wdata = row_eff | (LEAF'(1) << idx_cur);
    end
  end

  bba_ram #(.WIDTH(LEAF), .DEPTH(ROWS)) u_free_map (
    .clk   (clk),
    .we    (row_we),
    .waddr (cur_lvl),
    .wdata (row_wdata),
    .raddr (cur_lvl),
    .rdata (row_rd)
  );

  bba_ram #(.WIDTH(ORD_W), .DEPTH(LEAF)) u_ord_store (
    .clk   (clk),
    .we    (ctl.alloc_commit),
    .waddr (leaf),
    .wdata (ORD_W'(tgt_lvl) + ORD_W'(MIN_ORDER)),
    .raddr (leaf),
    .rdata (ord_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      in_use    <= '0;
    end else begin
      if (row_we) begin
        row_valid[cur_lvl] <= 1'b1;
      end
      if (ctl.alloc_commit) begin
        in_use[leaf] <= 1'b1;
      end else if (ctl.free_release) begin
        in_use[leaf] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_use_rd <= in_use[leaf];

    if (ctl.load) begin
      is_free   <= (cmd == bba_pkg::CMD_FREE);
      too_large <= 32'(total) > (32'd1 << MAX_ORDER);
      oob       <= (32'(free_offset) >> MAX_ORDER) != 32'd0;
      cur_off   <= (cmd == bba_pkg::CMD_FREE) ? OFF_W'(free_offset) : '0;
      cur_lvl   <= LVL_W'(k_calc - MIN_ORDER);
      tgt_lvl   <= LVL_W'(k_calc - MIN_ORDER);
    end else if (ctl.lvl_up) begin
      cur_lvl <= cur_lvl + LVL_W'(1);
    end else if (ctl.scan_take) begin
      cur_off <= OFF_W'(first_j) << ord_cur;
    end else if (ctl.split_step) begin
      cur_lvl <= cur_lvl - LVL_W'(1);
    end else if (ctl.free_release) begin
      cur_lvl <= LVL_W'(ord_rd - ORD_W'(MIN_ORDER));
    end else if (ctl.merge_step) begin
      cur_off <= cur_off & ~(OFF_W'(1) << ord_cur);
      cur_lvl <= cur_lvl + LVL_W'(1);
    end

    if (ctl.err) begin
      res_status <= ctl.err_code;
      res_off    <= '0;
      res_ord    <= '0;
    end else if (ctl.alloc_commit) begin
      res_status <= bba_pkg::ST_OK;
      res_off    <= cur_off;
      res_ord    <= ORD_W'(tgt_lvl) + ORD_W'(MIN_ORDER);
    end else if (ctl.set_commit) begin
      res_status <= bba_pkg::ST_OK;
      res_off    <= cur_off;
      res_ord    <= ord_cur;
    end
  end

  assign sts.is_free    = is_free;
  assign sts.too_large  = too_large;
  assign sts.row_any    = |row_eff;
  assign sts.lvl_top    = (cur_lvl == LVL_W'(DEPTH_LV));
  assign sts.lvl_at_tgt = (cur_lvl == tgt_lvl);
  assign sts.free_bad   = oob || !in_use_rd || (ord_rd < ORD_W'(MIN_ORDER)) ||
                          (ord_rd > ORD_W'(MAX_ORDER)) || mis;
  assign sts.mate_free  = (cur_lvl != LVL_W'(DEPTH_LV)) &&
                          row_eff[idx_cur ^ IDX_W'(1)];

  assign status       = res_status;
  assign block_offset = bba_pkg::OFFIN_W'(res_off);
  assign block_order  = bba_pkg::ORDOUT_W'(res_ord);

endmodule

// ----- design/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences search, split and merge steps and the beat handshakes.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::dp_cmd_t  ctl,
  input  bba_pkg::dp_sts_t  sts
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DEC     = 11'b000_0000_0010,
    S_A_SCAN  = 11'b000_0000_0100,
    S_A_RD    = 11'b000_0000_1000,
    S_SPL_CHK = 11'b000_0001_0000,
    S_SPL_RD  = 11'b000_0010_0000,
    S_SPL_WR  = 11'b000_0100_0000,
    S_F_CHK   = 11'b000_1000_0000,
    S_M_RD    = 11'b001_0000_0000,
    S_M_CHK   = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.err_code = bba_pkg::ST_OK;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts.is_free) begin
          state_next = S_F_CHK;
        end else if (sts.too_large) begin
          ctl.err      = 1'b1;
          ctl.err_code = bba_pkg::ST_TOO_LARGE;
          state_next   = S_OUT;
        end else begin
          state_next = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        priority if (sts.row_any) begin
          ctl.scan_take = 1'b1;
          state_next    = S_SPL_CHK;
        end else if (sts.lvl_top) begin
          ctl.err      = 1'b1;
          ctl.err_code = bba_pkg::ST_NO_FREE;
          state_next   = S_OUT;
        end else begin
          ctl.lvl_up = 1'b1;
          state_next = S_A_RD;
        end
      end
      S_A_RD: state_next = S_A_SCAN;
      S_SPL_CHK: begin
        if (sts.lvl_at_tgt) begin
          ctl.alloc_commit = 1'b1;
          state_next       = S_OUT;
        end else begin
          ctl.split_step = 1'b1;
          state_next     = S_SPL_RD;
        end
      end
      S_SPL_RD: state_next = S_SPL_WR;
      S_SPL_WR: begin
        ctl.split_wr = 1'b1;
        state_next   = S_SPL_CHK;
      end
      S_F_CHK: begin
        if (sts.free_bad) begin
          ctl.err      = 1'b1;
          ctl.err_code = bba_pkg::ST_BAD_FREE;
          state_next   = S_OUT;
        end else begin
          ctl.free_release = 1'b1;
          state_next       = S_M_RD;
        end
      end
      S_M_RD: state_next = S_M_CHK;
      S_M_CHK: begin
        if (sts.mate_free) begin
          ctl.merge_step = 1'b1;
          state_next     = S_M_RD;
        end else begin
          ctl.set_commit = 1'b1;
          state_next     = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            ctl.load   = 1'b1;
            state_next = S_DEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/buddy_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a pool of 2^MAX_ORDER bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd selects allocate or free; allocate
// uses req_bytes, free uses free_offset. Output channel (out_valid/out_ready)
// gives one beat per input beat: status, block_offset, block_order.
// One item at a time. Allocate searches upward through empty levels and
// then splits down to the target order; free merges upward with free
// buddies. Both walk the per-level free bitmap memory, one level per step.
// A new beat is taken in the cycle the pending result is taken.
// Reset leaves only the whole-pool block free and no block in use; it is
// immediate, no clearing pass. While out_ready is low the result holds and
// no new input is accepted.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit #(
  parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
  parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
  parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [bba_pkg::REQ_W-1:0]     req_bytes,
  input  logic [bba_pkg::OFFIN_W-1:0]   free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [bba_pkg::OFFIN_W-1:0]   block_offset,
  output logic [bba_pkg::ORDOUT_W-1:0]  block_order
);

  bba_pkg::dp_cmd_t ctl;
  bba_pkg::dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  bba_dp #(
    .MAX_ORDER    (MAX_ORDER),
    .MIN_ORDER    (MIN_ORDER),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_bytes    (req_bytes),
    .free_offset  (free_offset),
    .ctl          (ctl),
    .sts          (sts),
    .status       (status),
    .block_offset (block_offset),
    .block_order  (block_order)
  );

endmodule

// ----- design/bba_checker.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_unit_assert.svh"

module bba_checker #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
  parameter int MIN_ORDER = bba_pkg::MIN_ORDER_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          cmd,
  input logic [bba_pkg::REQ_W-1:0]     req_bytes,
  input logic [bba_pkg::OFFIN_W-1:0]   free_offset,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic [bba_pkg::OFFIN_W-1:0]   block_offset,
  input logic [bba_pkg::ORDOUT_W-1:0]  block_order
);

  logic [1:0] st_ok;
  assign st_ok = bba_pkg::ST_OK;

  `BBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
  `BBA_ASSERT_IMP(a_err_zero, out_valid && (status != st_ok),
                  (block_offset == '0) && (block_order == '0))
  `BBA_ASSERT_IMP(a_ok_order, out_valid && (status == st_ok),
                  (32'(block_order) >= MIN_ORDER) && (32'(block_order) <= MAX_ORDER))
  `BBA_ASSERT_IMP(a_one_item, in_valid && in_ready, !out_valid || out_ready)

endmodule

bind buddy_block_allocator_unit bba_checker #(
  .MAX_ORDER (MAX_ORDER),
  .MIN_ORDER (MIN_ORDER)
) u_bba_checker (.*);

// ----- tb/buddy_block_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free beats through a valid/ready driver, predicts each
// result with a behavioural buddy model and checks every output beat in order.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXO = 9;
  localparam int MINO = 1;
  localparam int HDR = 8;
  localparam int LEAVES = 1 << (MAXO - MINO);
  localparam int POOL = 1 << MAXO;

  typedef struct packed {
    logic        op;
    logic [15:0] nbytes;
    logic [8:0]  foff;
  } req_t;

  typedef struct packed {
    bba_pkg::status_t st;
    logic [8:0]       boff;
    logic [3:0]       bord;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = bba_pkg::CMD_ALLOC;
  logic [15:0] req_bytes = '0;
  logic [8:0] free_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [8:0] block_offset;
  logic [3:0] block_order;

  buddy_block_allocator_unit dut (.*);

  // behavioural state: free bit per order and block index
  bit          free_map[MAXO+1][LEAVES];
  logic [3:0]  ord_store[LEAVES];
  bit          in_use[LEAVES];
  int unsigned live_offs[$];

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    send_idle = 35;
  int    recv_idle = 45;
  bit    failed = 1'b0;

  function automatic resp_t alloc_block(int unsigned nbytes);
    resp_t r;
    int unsigned total;
    int k, o, j, off;
    bit found;
    total = nbytes + HDR;
    r = '{bba_pkg::ST_OK, 9'd0, 4'd0};
    k = MINO;
    while (k < MAXO && (1 << k) < total) k++;
    if ((1 << k) < total) begin
      r.st = bba_pkg::ST_TOO_LARGE;
      return r;
    end
    found = 1'b0;
    off = 0;
    for (o = k; o <= MAXO && !found; o++) begin
      for (j = 0; j < (1 << (MAXO - o)); j++) begin
        if (free_map[o][j]) begin
          found = 1'b1;
          free_map[o][j] = 1'b0;
          off = j << o;
          break;
        end
      end
      if (found) begin
        while (o > k) begin
          o--;
          free_map[o][(off >> o) + 1] = 1'b1;
        end
      end
    end
    if (!found) begin
      r.st = bba_pkg::ST_NO_FREE;
      return r;
    end
    ord_store[off >> MINO] = k[3:0];
    in_use[off >> MINO] = 1'b1;
    live_offs.push_back(off);
    r.boff = off[8:0];
    r.bord = k[3:0];
    return r;
  endfunction

  function automatic resp_t release_block(int unsigned off);
    resp_t r;
    int k, idx;
    r = '{bba_pkg::ST_BAD_FREE, 9'd0, 4'd0};
    if (off >= POOL || off[0] != 1'b0) return r;
    idx = off >> MINO;
    if (!in_use[idx]) return r;
    k = ord_store[idx];
    if ((off & ((1 << k) - 1)) != 0) return r;
    in_use[idx] = 1'b0;
    while (k < MAXO && free_map[k][(off ^ (1 << k)) >> k]) begin
      free_map[k][(off ^ (1 << k)) >> k] = 1'b0;
      off = off & ~(1 << k);
      k++;
    end
    free_map[k][off >> k] = 1'b1;
    r.st = bba_pkg::ST_OK;
    r.boff = off[8:0];
    r.bord = k[3:0];
    return r;
  endfunction

  function automatic void queue_req(logic op, logic [15:0] nb, logic [8:0] fo);
    pending_reqs.push_back('{op, nb, fo});
  endfunction

  // random free offset: mostly a live block, sometimes junk
  function automatic logic [8:0] pick_free_off();
    int i;
    if (live_offs.size() != 0 && $urandom_range(0, 9) < 8) begin
      i = $urandom_range(0, live_offs.size() - 1);
      return live_offs[i][8:0];
    end
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic logic [15:0] pick_bytes();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 511));
      default: return 16'($urandom_range(0, 60));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // driver; prediction is done here, in acceptance order
  always @(posedge clk) begin
    resp_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (cmd == bba_pkg::CMD_ALLOC) r = alloc_block(req_bytes);
        else r = release_block(free_offset);
        expected_resps.push_back(r);
        foreach (live_offs[i]) begin
          if (cmd == bba_pkg::CMD_FREE && r.st == bba_pkg::ST_OK &&
              live_offs[i] == free_offset) begin
            live_offs.delete(i);
            break;
          end
        end
      end
      if ((!in_valid || in_ready) && pending_reqs.size() != 0 &&
          $urandom_range(0, 99) >= send_idle) begin
        req_t q;
        q = pending_reqs.pop_front();
        if (q.op == bba_pkg::CMD_FREE && q.foff == 9'h1ff && q.nbytes == 16'hdead)
          q.foff = pick_free_off();
        in_valid <= 1'b1;
        cmd <= q.op;
        req_bytes <= q.nbytes;
        free_offset <= q.foff;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $error("result beat with nothing expected");
          failed = 1'b1;
        end else begin
          e = expected_resps.pop_front();
          if (status !== e.st) begin
            $error("status expected %0d got %0d", e.st, status);
            failed = 1'b1;
          end
          if (block_offset !== e.boff) begin
            $error("block_offset expected %0d got %0d", e.boff, block_offset);
            failed = 1'b1;
          end
          if (block_order !== e.bord) begin
            $error("block_order expected %0d got %0d", e.bord, block_order);
            failed = 1'b1;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    int n, phase;
    for (int o = 0; o <= MAXO; o++)
      for (int j = 0; j < LEAVES; j++) free_map[o][j] = 1'b0;
    for (int j = 0; j < LEAVES; j++) begin
      in_use[j] = 1'b0;
      ord_store[j] = '0;
    end
    free_map[MAXO][0] = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, errors, exhaustion, merges
    queue_req(bba_pkg::CMD_FREE, 16'hffff, 9'd0);
    queue_req(bba_pkg::CMD_ALLOC, 16'hffff, 9'h1ff);
    queue_req(bba_pkg::CMD_ALLOC, 16'd505, 9'd0);
    queue_req(bba_pkg::CMD_ALLOC, 16'd504, 9'd0);
    queue_req(bba_pkg::CMD_ALLOC, 16'd0, 9'd0);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd0);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd1);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'h1ff);
    queue_req(bba_pkg::CMD_ALLOC, 16'd0, 9'h1ff);
    queue_req(bba_pkg::CMD_ALLOC, 16'd0, 9'd0);
    queue_req(bba_pkg::CMD_ALLOC, 16'd8, 9'd0);
    queue_req(bba_pkg::CMD_ALLOC, 16'd100, 9'd0);
    queue_req(bba_pkg::CMD_ALLOC, 16'd200, 9'd0);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd8);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd16);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd0);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd128);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd256);
    queue_req(bba_pkg::CMD_FREE, 16'd0, 9'd0);
    queue_req(bba_pkg::CMD_ALLOC, 16'h8000, 9'd0);
    queue_req(bba_pkg::CMD_FREE, 16'h5555, 9'h0aa);

    // random; a free with nbytes 'dead and offset 1ff is resolved at issue
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 35; recv_idle = 45; end
        1: begin send_idle = 45; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (n = 0; n < 500; n++) begin
        if ($urandom_range(0, 1))
          queue_req(bba_pkg::CMD_ALLOC, pick_bytes(), 9'($urandom_range(0, 511)));
        else if ($urandom_range(0, 19) == 0)
          queue_req(bba_pkg::CMD_FREE, 16'($urandom()), 9'($urandom_range(0, 511)));
        else
          queue_req(bba_pkg::CMD_FREE, 16'hdead, 9'h1ff);
      end
      wait (pending_reqs.size() == 0 && !in_valid);
    end
    wait (expected_resps.size() == 0);
    repeat (60) @(posedge clk);
    if (!failed && expected_resps.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
